// ----- rtl/wvd_pkg.sv -----
// wvd_pkg: shared types and constants of the wind vane direction decoder
// no dependencies
package wvd_pkg;

  localparam int POS = 16;
  localparam int OW  = 20;
  localparam int OHMS_BITS = 20;

  localparam logic [2:0] MODE_MEASURE = 3'd0;
  localparam logic [2:0] MODE_STAGE   = 3'd1;
  localparam logic [2:0] MODE_COMMIT  = 3'd2;
  localparam logic [2:0] MODE_RESTORE = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;
  localparam logic [2:0] MODE_LOOKUP  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  localparam logic [1:0] REG_SERIES = 2'd0;
  localparam logic [1:0] REG_SUPPLY = 2'd1;
  localparam logic [1:0] REG_MTOL   = 2'd2;

  localparam logic [11:0] DEG_STEP = 12'd225;

  function automatic logic [OW-1:0] default_ohms(input logic [3:0] i);
    logic [OW-1:0] v;
    unique case (i)
      4'd0:  v = 20'd33000;
      4'd1:  v = 20'd6570;
      4'd2:  v = 20'd8200;
      4'd3:  v = 20'd891;
      4'd4:  v = 20'd1000;
      4'd5:  v = 20'd688;
      4'd6:  v = 20'd2200;
      4'd7:  v = 20'd1410;
      4'd8:  v = 20'd3900;
      4'd9:  v = 20'd3140;
      4'd10: v = 20'd16000;
      4'd11: v = 20'd14120;
      4'd12: v = 20'd120000;
      4'd13: v = 20'd42120;
      4'd14: v = 20'd64900;
      default: v = 20'd21880;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] sample_mv;
    logic [3:0]  entry_index;
    logic [19:0] entry_ohms;
    logic [16:0] commit_tolerance;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  direction_index;
    logic [11:0] degrees_tenths;
    logic [19:0] ohms;
    logic [16:0] separation;
  } rsp_t;

endpackage

// ----- rtl/wvd_if.sv -----
// wvd_if: valid/ready channel carrying one payload
// depends on wvd_pkg
interface wvd_if import wvd_pkg::*; #(parameter type T = req_t) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/wind_vane_direction_decoder.sv -----
// wind_vane_direction_decoder: top level, sequencer around one shared divider
// depends on wvd_pkg and wvd_if
//
//   channel | dir | contents
//   req     | in  | mode, sample_mv, entry_index, entry_ohms, commit_tolerance
//   rsp     | out | status, direction_index, degrees_tenths, ohms, separation
//   apb     | in  | series_res, supply_mv, match_tolerance
//
// one request at a time; ready is low while it is worked on
// divider: 36-bit restoring, one quotient bit a cycle
// measure: resistance division plus 16 error divisions
// lookup: 16 error divisions
// commit: up to 16 zero checks, then 120 pair divisions if no staged entry is zero
// stage, read, restore: result the cycle after accept; rsp holds until taken
module wind_vane_direction_decoder import wvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  wvd_if.sink         req,
  wvd_if.source       rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // divider width: dividend up to 36-bit product or a <<16 of a difference
  localparam int DW = (OHMS_BITS + 16 > 36) ? OHMS_BITS + 16 : 36;
  localparam int CW = $clog2(DW + 1);
  localparam logic [OHMS_BITS-1:0] RMAX = '1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MREG  = 4'd1;
  localparam logic [3:0] S_MDIV  = 4'd2;
  localparam logic [3:0] S_MSET  = 4'd3;
  localparam logic [3:0] S_ELOAD = 4'd4;
  localparam logic [3:0] S_EDIV  = 4'd5;
  localparam logic [3:0] S_ENEXT = 4'd6;
  localparam logic [3:0] S_ZCHK  = 4'd7;
  localparam logic [3:0] S_PLOAD = 4'd8;
  localparam logic [3:0] S_PDIV  = 4'd9;
  localparam logic [3:0] S_PNEXT = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;

  // configuration
  logic [19:0] series_res;
  logic [15:0] supply_mv;
  logic [16:0] match_tolerance;
  logic wr;
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_res <= 20'd10000;
      supply_mv <= 16'd3300;
      match_tolerance <= 17'd6554;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_SERIES: series_res <= pwdata[19:0];
        REG_SUPPLY: supply_mv <= pwdata[15:0];
        REG_MTOL:   match_tolerance <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SERIES: prdata = {12'd0, series_res};
      REG_SUPPLY: prdata = {16'd0, supply_mv};
      REG_MTOL:   prdata = {15'd0, match_tolerance};
      default:    prdata = 32'd0;
    endcase
  end

  // tables held in flops; read at index counters, and at the request's entry index for read
  logic [OHMS_BITS-1:0] active [POS];
  logic [OHMS_BITS-1:0] staged [POS];

  req_t cur;
  rsp_t res;
  logic [3:0] ia, ib;       // loop indices
  logic [OHMS_BITS-1:0] r;  // resistance being matched
  logic [DW-1:0] best_err;
  logic [3:0] best_idx;
  logic [16:0] sep;

  // shared restoring divider, one quotient bit a cycle
  logic [DW-1:0] dnum, dquo;
  logic [DW:0]   drem;
  logic [DW:0]   dden;
  logic [CW-1:0] dcnt;
  logic [DW:0]   trial;
  assign trial = {drem[DW-1:0], dnum[DW-1]} - dden;

  logic [OHMS_BITS-1:0] ta, tb, lo, hi;
  logic [OHMS_BITS-1:0] diff_r;
  assign ta = active[ia];
  assign diff_r = (r > ta) ? r - ta : ta - r;
  assign lo = (staged[ia] > staged[ib]) ? staged[ib] : staged[ia];
  assign hi = (staged[ia] > staged[ib]) ? staged[ia] : staged[ib];
  assign tb = hi - lo;

  logic [DW-1:0] prod;
  logic [16:0] qsep, nsep;
  assign qsep = (dquo > DW'(65536)) ? 17'd65536 : dquo[16:0];
  assign nsep = (qsep < sep) ? qsep : sep;

  // saturated resistance from the measure division
  logic [OHMS_BITS-1:0] rsat;
  assign rsat = (dquo > DW'(RMAX)) ? RMAX : dquo[OHMS_BITS-1:0];

  // running best match including the error just divided; first index wins ties
  logic take;
  logic [DW-1:0] fin_err;
  logic [3:0] fin_idx;
  assign take = (ia == 4'd0) || (dquo < best_err);
  assign fin_err = take ? dquo : best_err;
  assign fin_idx = take ? ia : best_idx;

  // first response contents and next state for an accepted request
  rsp_t start_res;
  logic [3:0] start_state;
  logic bad_reading;
  assign bad_reading = (req.data.sample_mv == 16'd0) || (req.data.sample_mv >= supply_mv) ||
                       (series_res == 20'd0);

  always_comb begin
    start_res = '0;
    start_state = S_OUT;
    unique case (req.data.mode)
      MODE_MEASURE: begin
        if (bad_reading) start_res.status = ST_INVALID;
        else start_state = S_MREG;
      end
      MODE_LOOKUP: begin
        if (req.data.entry_ohms == 20'd0) start_res.status = ST_INVALID;
        else begin
          start_res.ohms = req.data.entry_ohms;
          start_state = S_ELOAD;
        end
      end
      MODE_STAGE: begin
        start_res.direction_index = req.data.entry_index;
        start_res.degrees_tenths = 12'(req.data.entry_index * DEG_STEP);
        start_res.ohms = req.data.entry_ohms;
      end
      MODE_READ: begin
        start_res.direction_index = req.data.entry_index;
        start_res.degrees_tenths = 12'(req.data.entry_index * DEG_STEP);
        start_res.ohms = active[req.data.entry_index];
      end
      MODE_COMMIT: start_state = S_ZCHK;
      default: ;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign rsp.data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < POS; i++) begin
        active[i] <= OHMS_BITS'(default_ohms(4'(i)));
        staged[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (req.valid) begin
          cur <= req.data;
          res <= start_res;
          ia <= '0;
          ib <= 4'd1;
          best_err <= '1;
          best_idx <= '0;
          sep <= 17'd65536;
          prod <= DW'(series_res) * DW'(supply_mv - req.data.sample_mv);
          r <= OHMS_BITS'(req.data.entry_ohms);
          if (req.data.mode == MODE_STAGE) begin
            staged[req.data.entry_index] <= OHMS_BITS'(req.data.entry_ohms);
          end
          if (req.data.mode == MODE_RESTORE) begin
            for (int i = 0; i < POS; i++)
              active[i] <= OHMS_BITS'(default_ohms(4'(i)));
          end
          state <= start_state;
        end
        S_MREG: begin
          dnum <= prod;
          dden <= (DW+1)'(cur.sample_mv);
          drem <= '0;
          dcnt <= CW'(DW);
          state <= S_MDIV;
        end
        S_MDIV, S_EDIV, S_PDIV: begin
          if (dcnt == '0) begin
            state <= (state == S_MDIV) ? S_MSET : (state == S_EDIV) ? S_ENEXT : S_PNEXT;
          end else begin
            dnum <= dnum << 1;
            if (!trial[DW]) begin
              drem <= trial;
              dquo <= {dquo[DW-2:0], 1'b1};
            end else begin
              drem <= {drem[DW-1:0], dnum[DW-1]};
              dquo <= {dquo[DW-2:0], 1'b0};
            end
            dcnt <= dcnt - 1'b1;
          end
        end
        S_MSET: begin
          // saturate the computed resistance
          r <= rsat;
          res.ohms <= rsat;
          state <= S_ELOAD;
        end
        S_ELOAD: begin
          // relative error of entry ia; an empty entry counts as worst
          if (ta == '0) begin
            dnum <= '1;
            dden <= (DW+1)'(1);
          end else begin
            dnum <= DW'({diff_r, 16'd0});
            dden <= (DW+1)'(ta);
          end
          drem <= '0;
          dcnt <= CW'(DW);
          state <= S_EDIV;
        end
        S_ENEXT: begin
          if (take) begin
            best_err <= dquo;
            best_idx <= ia;
          end
          if (ia == 4'(POS-1)) begin
            if (fin_err > DW'(match_tolerance)) res.status <= ST_NOMATCH;
            else begin
              res.direction_index <= fin_idx;
              res.degrees_tenths <= 12'(fin_idx * DEG_STEP);
            end
            state <= S_OUT;
          end else begin
            ia <= ia + 4'd1;
            state <= S_ELOAD;
          end
        end
        S_ZCHK: begin
          if (staged[ia] == '0) begin
            res.status <= ST_REJECT;
            state <= S_OUT;
          end else if (ia == 4'(POS-1)) begin
            ia <= '0;
            ib <= 4'd1;
            state <= S_PLOAD;
          end else ia <= ia + 4'd1;
        end
        S_PLOAD: begin
          dnum <= DW'({tb, 16'd0});
          dden <= (DW+1)'(lo) + (DW+1)'(hi);
          drem <= '0;
          dcnt <= CW'(DW);
          state <= S_PDIV;
        end
        S_PNEXT: begin
          sep <= nsep;
          if (ib == 4'(POS-1)) begin
            if (ia == 4'(POS-2)) begin
              res.separation <= nsep;
              if (nsep > cur.commit_tolerance) begin
                for (int i = 0; i < POS; i++) active[i] <= staged[i];
              end else res.status <= ST_REJECT;
              state <= S_OUT;
            end else begin
              ia <= ia + 4'd1;
              ib <= ia + 4'd2;
              state <= S_PLOAD;
            end
          end else begin
            ib <= ib + 4'd1;
            state <= S_PLOAD;
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("result changed while stalled");
  a_invalid_fields: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.status == ST_INVALID |-> rsp.data.ohms == 20'd0)
    else $error("invalid reading with nonzero ohms");

endmodule
